### design/rsos_pkg.sv
// Package for the ray segment optical splitter.
// Holds the fixed-point constants, the CORDIC arctangent table and the sequencer states.
// No dependencies.
`default_nettype none

package rsos_pkg;

  localparam int FracBits     = 16;
  localparam int MaxCutsDef   = 64;
  localparam int CordicIters  = 16;
  localparam int DivSteps     = 24 + 2 * FracBits;
  localparam logic [23:0] MaxOptReset = 24'd655360;
  localparam logic signed [32:0] CordicK = 33'sd652032874;

  typedef enum logic [4:0] {
    S_IDLE, S_CORD, S_CFIN, S_M_LS, S_M_TAU, S_TAUCHK, S_DIV_T, S_M_DEN,
    S_LD_L, S_DIV_L, S_M_TS, S_M_DX, S_M_DY, S_M_DZ, S_M_USED, S_REM, S_EMIT
  } rsos_state_e;

  function automatic logic [31:0] atan_lut(input logic [3:0] i);
    logic [31:0] v;
    case (i)
      4'd0:  v = 32'd536870912;
      4'd1:  v = 32'd316933406;
      4'd2:  v = 32'd167458907;
      4'd3:  v = 32'd85004756;
      4'd4:  v = 32'd42667331;
      4'd5:  v = 32'd21354465;
      4'd6:  v = 32'd10679838;
      4'd7:  v = 32'd5340245;
      4'd8:  v = 32'd2670163;
      4'd9:  v = 32'd1335087;
      4'd10: v = 32'd667544;
      4'd11: v = 32'd333772;
      4'd12: v = 32'd166886;
      4'd13: v = 32'd83443;
      4'd14: v = 32'd41722;
      default: v = 32'd20861;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### design/ray_segment_optical_splitter.sv
// Top level of the ray segment optical splitter: sequencer, shared CORDIC stage,
// shared multiplier, shared restoring divider and piece emitter. Uses rsos_pkg.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_stall_o    segment fields
// out       source     out_valid_o / out_stall_i  one piece per beat
// cfg       sink       cfg_we_i                   cfg_wdata_i (max optical length)
//
// One segment is handled at a time. After a beat is taken, the shared CORDIC stage runs
// 16 iterations for each of the two angles, the shared multiplier is used up to eight
// times and, when the segment is cut, the shared divider runs 56 steps twice.
// Reset clears the sequencer, the slot counter and loads the default maximum.
// The pieces sit in registers and hold while out_stall_i is high.

module ray_segment_optical_splitter
  import rsos_pkg::*;
#(
  parameter int MaxCuts = MaxCutsDef
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [23:0]        cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                new_track_i,
  input  wire  [23:0]        seg_length_i,
  input  wire  [23:0]        sigma_max_i,
  input  wire  [23:0]        region_id_i,
  input  wire  [15:0]        track_index_i,
  input  wire  signed [20:0] surface_forward_i,
  input  wire  signed [20:0] surface_backward_i,
  input  wire  signed [31:0] start_x_i,
  input  wire  signed [31:0] start_y_i,
  input  wire  signed [31:0] start_z_i,
  input  wire  [15:0]        azimuth_i,
  input  wire  [15:0]        polar_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [23:0]        piece_length_o,
  output logic [23:0]        piece_region_o,
  output logic [15:0]        piece_track_o,
  output logic signed [31:0] piece_x_o,
  output logic signed [31:0] piece_y_o,
  output logic signed [31:0] piece_z_o,
  output logic signed [20:0] piece_surface_forward_o,
  output logic signed [20:0] piece_surface_backward_o,
  output logic [23:0]        slot_index_o,
  output logic               last_piece_o
);

  localparam int CutW = $clog2(MaxCuts + 1);
  localparam int DivCntW = $clog2(DivSteps);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  rsos_state_e state_q, state_d;

  logic [23:0] maxt_q, maxt_eff, counter_q;
  logic        in_acc, out_acc, last_k;

  // Latched segment.
  logic [23:0] len_q, sig_q, region_q;
  logic [15:0] track_q, azim_q;
  logic signed [20:0] sfwd_q, sbwd_q;
  logic [31:0] px_q, py_q, pz_q;

  // Shared CORDIC stage.
  logic signed [32:0] cx_q, cy_q, cx_d, cy_d, xs, ys;
  logic signed [31:0] cz_q, cz_d;
  logic [3:0]  iter_q;
  logic        phase_q;
  logic [1:0]  quad_q;
  logic [16:0] sm, cm;
  logic signed [17:0] s_new, c_new, st_q, ct_q, sp_q, cp_q;

  // Shared multiplier.
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] prod_q;

  // Shared divider.
  logic [DivSteps-1:0] num_q;
  logic [41:0] rem_q, rem_d, rtry;
  logic [40:0] den_q;
  logic [23:0] quo_q, quo_d;
  logic        ovf_q, ovf_d, ge;
  logic [DivCntW-1:0] dcnt_q;

  logic [CutW-1:0] cuts_q, k_q;
  logic [23:0] temp_q, rem_len_q, ts_q;
  logic [31:0] dx_q, dy_q, dz_q;
  logic [32:0] tau;
  logic [30:0] used;

  function automatic logic [16:0] to_frac(input logic signed [32:0] v);
    logic [18:0] m;
    m = 19'(({1'b0, v[31:0]} + 33'd8192) >> 14);
    if (v < 0) begin
      m = '0;
    end
    if (m > 19'd65536) begin
      m = 19'd65536;
    end
    return m[16:0];
  endfunction

  assign maxt_eff   = (maxt_q == '0) ? 24'd1 : maxt_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_EMIT);
  assign out_acc    = out_valid_o && !out_stall_i;
  assign last_k     = (k_q == cuts_q - CutW'(1));

  // CORDIC iteration with floor shifts.
  always_comb begin
    xs = cx_q >>> iter_q;
    ys = cy_q >>> iter_q;
    if (cz_q >= 0) begin
      cx_d = cx_q - ys;
      cy_d = cy_q + xs;
      cz_d = cz_q - $signed(atan_lut(iter_q));
    end else begin
      cx_d = cx_q + ys;
      cy_d = cy_q - xs;
      cz_d = cz_q + $signed(atan_lut(iter_q));
    end
    cm = to_frac(cx_q);
    sm = to_frac(cy_q);
    case (quad_q)
      2'd0: begin s_new = $signed({1'b0, sm});  c_new = $signed({1'b0, cm});  end
      2'd1: begin s_new = $signed({1'b0, cm});  c_new = -$signed({1'b0, sm}); end
      2'd2: begin s_new = -$signed({1'b0, sm}); c_new = -$signed({1'b0, cm}); end
      default: begin s_new = -$signed({1'b0, cm}); c_new = $signed({1'b0, sm}); end
    endcase
  end

  // Restoring divider step, quotient saturating through a sticky overflow.
  always_comb begin
    rtry  = {rem_q[40:0], num_q[DivSteps-1]};
    ge    = (rtry >= {1'b0, den_q});
    rem_d = ge ? (rtry - {1'b0, den_q}) : rtry;
    quo_d = {quo_q[22:0], ge};
    ovf_d = ovf_q | quo_q[23];
  end

  assign tau  = prod_q[48:16];
  assign used = prod_q[30:0];

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_M_LS: begin
        mul_a = {10'b0, len_q};
        mul_b = {1'b0, sig_q};
      end
      S_M_TAU: begin
        mul_a = {2'b0, prod_q[47:16]};
        mul_b = (st_q > 0) ? 25'(st_q) : '0;
      end
      S_M_DEN: begin
        mul_a = 34'(st_q);
        mul_b = {1'b0, sig_q};
      end
      S_M_TS: begin
        mul_a = {10'b0, temp_q};
        mul_b = 25'(st_q);
      end
      S_M_DX: begin
        mul_a = {9'b0, prod_q[40:16]};
        mul_b = 25'(cp_q);
      end
      S_M_DY: begin
        mul_a = {10'b0, ts_q};
        mul_b = 25'(sp_q);
      end
      S_M_DZ: begin
        mul_a = {10'b0, temp_q};
        mul_b = 25'(ct_q);
      end
      S_M_USED: begin
        mul_a = 34'(cuts_q - CutW'(1));
        mul_b = {1'b0, temp_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_CORD;
      S_CORD:   if (iter_q == 4'(CordicIters - 1)) state_d = S_CFIN;
      S_CFIN:   state_d = phase_q ? S_M_LS : S_CORD;
      S_M_LS:   state_d = S_M_TAU;
      S_M_TAU:  state_d = S_TAUCHK;
      S_TAUCHK: state_d = ({9'b0, maxt_eff} < tau) ? S_DIV_T : S_EMIT;
      S_DIV_T:  if (dcnt_q == DivLast) state_d = S_M_DEN;
      S_M_DEN:  state_d = S_LD_L;
      S_LD_L:   state_d = S_DIV_L;
      S_DIV_L:  if (dcnt_q == DivLast) state_d = S_M_TS;
      S_M_TS:   state_d = S_M_DX;
      S_M_DX:   state_d = S_M_DY;
      S_M_DY:   state_d = S_M_DZ;
      S_M_DZ:   state_d = S_M_USED;
      S_M_USED: state_d = S_REM;
      S_REM:    state_d = S_EMIT;
      S_EMIT:   if (out_acc && last_k) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      maxt_q    <= MaxOptReset;
      counter_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        maxt_q <= cfg_wdata_i;
      end
      if (in_acc && new_track_i) begin
        counter_q <= '0;
      end else if (out_acc && counter_q != 24'hFFFFFF) begin
        counter_q <= counter_q + 24'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_acc) begin
      len_q    <= seg_length_i;
      sig_q    <= sigma_max_i;
      region_q <= region_id_i;
      track_q  <= track_index_i;
      sfwd_q   <= surface_forward_i;
      sbwd_q   <= surface_backward_i;
      px_q     <= start_x_i;
      py_q     <= start_y_i;
      pz_q     <= start_z_i;
      azim_q   <= azimuth_i;
      cx_q     <= CordicK;
      cy_q     <= '0;
      cz_q     <= {2'b0, polar_i[13:0], 16'b0};
      quad_q   <= polar_i[15:14];
      iter_q   <= '0;
      phase_q  <= 1'b0;
    end
    unique case (state_q)
      S_CORD: begin
        cx_q   <= cx_d;
        cy_q   <= cy_d;
        cz_q   <= cz_d;
        iter_q <= iter_q + 4'd1;
      end
      S_CFIN: begin
        if (phase_q) begin
          sp_q <= s_new;
          cp_q <= c_new;
        end else begin
          st_q <= s_new;
          ct_q <= c_new;
        end
        cx_q    <= CordicK;
        cy_q    <= '0;
        cz_q    <= {2'b0, azim_q[13:0], 16'b0};
        quad_q  <= azim_q[15:14];
        iter_q  <= '0;
        phase_q <= 1'b1;
      end
      S_TAUCHK: begin
        cuts_q    <= CutW'(1);
        temp_q    <= '0;
        rem_len_q <= len_q;
        k_q       <= '0;
        num_q     <= DivSteps'(tau);
        den_q     <= {17'b0, maxt_eff};
        rem_q     <= '0;
        quo_q     <= '0;
        ovf_q     <= 1'b0;
        dcnt_q    <= '0;
      end
      S_DIV_T, S_DIV_L: begin
        num_q  <= num_q << 1;
        rem_q  <= rem_d;
        quo_q  <= quo_d;
        ovf_q  <= ovf_d;
        dcnt_q <= dcnt_q + DivCntW'(1);
        if (dcnt_q == DivLast) begin
          if (state_q == S_DIV_T) begin
            if (ovf_d || quo_d >= 24'(MaxCuts)) begin
              cuts_q <= CutW'(MaxCuts);
            end else begin
              cuts_q <= CutW'(quo_d + 24'd1);
            end
          end else begin
            temp_q <= ovf_d ? 24'hFFFFFF : quo_d;
          end
        end
      end
      S_LD_L: begin
        num_q  <= {maxt_eff, (2 * FracBits)'(0)};
        den_q  <= prod_q[40:0];
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
        dcnt_q <= '0;
      end
      // The step along the track never exceeds the piece length, so 24 bits hold it.
      S_M_DX: ts_q <= prod_q[39:16];
      S_M_DY: dx_q <= prod_q[47:16];
      S_M_DZ: dy_q <= prod_q[47:16];
      S_M_USED: dz_q <= prod_q[47:16];
      S_REM: rem_len_q <= ({7'b0, len_q} >= used) ? 24'({7'b0, len_q} - used) : '0;
      S_EMIT: begin
        if (out_acc) begin
          k_q  <= k_q + CutW'(1);
          px_q <= px_q + dx_q;
          py_q <= py_q + dy_q;
          pz_q <= pz_q + dz_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign piece_length_o          = last_k ? rem_len_q : temp_q;
  assign piece_region_o          = region_q;
  assign piece_track_o           = track_q;
  assign piece_x_o               = px_q;
  assign piece_y_o               = py_q;
  assign piece_z_o               = pz_q;
  assign piece_surface_forward_o = last_k ? sfwd_q : -21'sd1;
  assign piece_surface_backward_o = (k_q == '0) ? sbwd_q : -21'sd1;
  assign slot_index_o            = counter_q;
  assign last_piece_o            = last_k;

`ifndef NO_ASSERTIONS
  a_busy_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while emitting");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_piece_o) |=> !out_valid_o) else $error("emission ran past last piece");
  a_cuts_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cuts_q != '0 && cuts_q <= CutW'(MaxCuts) && k_q < cuts_q))
    else $error("piece count out of range");
  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_piece_o && slot_index_o != 24'hFFFFFF)
    |=> slot_index_o == $past(slot_index_o) + 24'd1) else $error("slot index skipped");
`endif

endmodule

`default_nettype wire

### dv/rsos_checker.sv
// Checker for the ray segment optical splitter: watches both channels, predicts pieces.
// Depends on rsos_pkg (FracBits, MaxOptReset) and on the config port the testbench drives.
`default_nettype none

module rsos_checker
  import rsos_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire        [23:0] cfg_wdata_i,
  input  wire               in_valid_i,
  input  wire               in_stall_o,
  input  wire               new_track_i,
  input  wire        [23:0] seg_length_i,
  input  wire        [23:0] sigma_max_i,
  input  wire        [23:0] region_id_i,
  input  wire        [15:0] track_index_i,
  input  wire        [20:0] surface_forward_i,
  input  wire        [20:0] surface_backward_i,
  input  wire        [31:0] start_x_i,
  input  wire        [31:0] start_y_i,
  input  wire        [31:0] start_z_i,
  input  wire        [15:0] azimuth_i,
  input  wire        [15:0] polar_i,
  input  wire               out_valid_o,
  input  wire               out_stall_i,
  input  wire        [23:0] piece_length_o,
  input  wire        [23:0] piece_region_o,
  input  wire        [15:0] piece_track_o,
  input  wire        [31:0] piece_x_o,
  input  wire        [31:0] piece_y_o,
  input  wire        [31:0] piece_z_o,
  input  wire        [20:0] piece_surface_forward_o,
  input  wire        [20:0] piece_surface_backward_o,
  input  wire        [23:0] slot_index_o,
  input  wire               last_piece_o,
  output int                fail_count,
  output int                pending_pieces
);

  typedef struct packed {
    logic [23:0] len;
    logic [23:0] region;
    logic [15:0] track;
    logic [31:0] x, y, z;
    logic [20:0] sfwd, sbwd;
    logic [23:0] slot;
    logic        last;
  } piece_t;

  piece_t      piece_q[$];
  logic [23:0] max_opt;
  logic [23:0] slot_ctr;

  localparam longint AtanTab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722,
    20861};

  assign pending_pieces = piece_q.size();

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_to_frac(longint q);
    longint m;
    if (q < 0) q = 0;
    m = (q + (64'sd1 <<< (29 - FracBits))) >>> (30 - FracBits);
    if (m > (64'sd1 <<< FracBits)) m = 64'sd1 <<< FracBits;
    return m;
  endfunction

  task automatic sine_cosine(input logic [15:0] ang, output longint s, output longint c);
    longint x, y, z, nx, sm, cm;
    x = 652032874;
    y = 0;
    z = longint'(ang[13:0]) <<< 16;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y  = y + floor_shift(x, i);
        z -= AtanTab[i];
      end else begin
        nx = x + floor_shift(y, i);
        y  = y - floor_shift(x, i);
        z += AtanTab[i];
      end
      x = nx;
    end
    cm = q30_to_frac(x);
    sm = q30_to_frac(y);
    case (ang[15:14])
      2'd0: begin s = sm;  c = cm;  end
      2'd1: begin s = cm;  c = -sm; end
      2'd2: begin s = -sm; c = -cm; end
      default: begin s = -cm; c = sm; end
    endcase
  endtask

  // Expand one accepted segment into its pieces.
  task automatic split_segment();
    longint st, ct, sp, cp, dx, dy, dz, ts;
    longint unsigned len, sig, maxt, tau, quo, piece, used, rem, prod;
    int cuts;
    piece_t p;
    dx = 0; dy = 0; dz = 0; tau = 0; piece = 0; cuts = 1;
    len = seg_length_i;
    sig = sigma_max_i;
    maxt = (max_opt == 0) ? 1 : max_opt;
    if (new_track_i) slot_ctr = '0;
    sine_cosine(polar_i, st, ct);
    sine_cosine(azimuth_i, sp, cp);
    if (st > 0) tau = (((len * sig) >> FracBits) * longint'(st)) >> FracBits;
    if (tau > maxt) begin
      quo = tau / maxt;
      cuts = (quo >= 64) ? 64 : int'(quo + 1);
    end
    if (cuts > 1) begin
      // Saturating division; the shifted numerator fits in 56 bits.
      prod = sig * longint'(st);
      quo = (maxt << (2 * FracBits)) / prod;
      piece = (quo > 24'hFFFFFF) ? 24'hFFFFFF : quo;
      ts = longint'((piece * longint'(st)) >> FracBits);
      dx = floor_shift(ts * cp, FracBits);
      dy = floor_shift(ts * sp, FracBits);
      dz = floor_shift(longint'(piece) * ct, FracBits);
    end
    used = longint'(cuts - 1) * piece;
    rem = (len >= used) ? len - used : 0;
    p.region = region_id_i;
    p.track  = track_index_i;
    p.x = start_x_i;
    p.y = start_y_i;
    p.z = start_z_i;
    for (int k = 0; k < cuts; k++) begin
      p.last = (k == cuts - 1);
      p.len  = p.last ? rem[23:0] : piece[23:0];
      p.sfwd = p.last ? surface_forward_i : 21'h1FFFFF;
      p.sbwd = (k == 0) ? surface_backward_i : 21'h1FFFFF;
      p.slot = slot_ctr;
      piece_q.push_back(p);
      if (slot_ctr != 24'hFFFFFF) slot_ctr++;
      p.x = p.x + dx[31:0];
      p.y = p.y + dy[31:0];
      p.z = p.z + dz[31:0];
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  piece_t seen, want;

  initial fail_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_opt  = MaxOptReset;
      slot_ctr = '0;
      piece_q.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen = '{piece_length_o, piece_region_o, piece_track_o, piece_x_o, piece_y_o,
                 piece_z_o, piece_surface_forward_o, piece_surface_backward_o,
                 slot_index_o, last_piece_o};
        if (piece_q.size() == 0) begin
          report_mismatch("piece beat with nothing expected");
        end else begin
          want = piece_q.pop_front();
          if (seen.len != want.len) report_mismatch($sformatf("length %h want %h", seen.len, want.len));
          if (seen.region != want.region) report_mismatch("region");
          if (seen.track != want.track) report_mismatch("track");
          if (seen.x != want.x) report_mismatch($sformatf("x %h want %h", seen.x, want.x));
          if (seen.y != want.y) report_mismatch($sformatf("y %h want %h", seen.y, want.y));
          if (seen.z != want.z) report_mismatch($sformatf("z %h want %h", seen.z, want.z));
          if (seen.sfwd != want.sfwd) report_mismatch("surface forward");
          if (seen.sbwd != want.sbwd) report_mismatch("surface backward");
          if (seen.slot != want.slot) report_mismatch($sformatf("slot %0d want %0d", seen.slot, want.slot));
          if (seen.last != want.last) report_mismatch("last piece flag");
        end
      end
      if (in_valid_i && !in_stall_o) split_segment();
      if (cfg_we_i) max_opt = cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

### dv/tb_top.sv
// Testbench top for the ray segment optical splitter: clock, reset, stimulus and verdict.
// Depends on rsos_pkg, the block itself and rsos_checker.
`default_nettype none

module tb_top
  import rsos_pkg::*;
;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        new_track = 1'b0;
  logic [23:0] seg_length = '0, sigma_max = '0, region_id = '0;
  logic [15:0] track_index = '0, azimuth = '0, polar = '0;
  logic [20:0] surface_forward = '0, surface_backward = '0;
  logic [31:0] start_x = '0, start_y = '0, start_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [23:0] piece_length, piece_region, slot_index;
  logic [15:0] piece_track;
  logic [31:0] piece_x, piece_y, piece_z;
  logic [20:0] piece_sfwd, piece_sbwd;
  logic        last_piece;
  int          fail_count, pending_pieces;

  // Knobs for the receiver process: random stalls, a long hold-off, or none at all.
  bit          quiet_phase = 1'b0;
  bit          hold_request = 1'b0;

  always #1 clk = ~clk;

  ray_segment_optical_splitter DUT (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .new_track_i(new_track),
    .seg_length_i(seg_length), .sigma_max_i(sigma_max), .region_id_i(region_id),
    .track_index_i(track_index), .surface_forward_i(surface_forward),
    .surface_backward_i(surface_backward), .start_x_i(start_x), .start_y_i(start_y),
    .start_z_i(start_z), .azimuth_i(azimuth), .polar_i(polar),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .piece_length_o(piece_length),
    .piece_region_o(piece_region), .piece_track_o(piece_track), .piece_x_o(piece_x),
    .piece_y_o(piece_y), .piece_z_o(piece_z), .piece_surface_forward_o(piece_sfwd),
    .piece_surface_backward_o(piece_sbwd), .slot_index_o(slot_index),
    .last_piece_o(last_piece)
  );

  rsos_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .new_track_i(new_track),
    .seg_length_i(seg_length), .sigma_max_i(sigma_max), .region_id_i(region_id),
    .track_index_i(track_index), .surface_forward_i(surface_forward),
    .surface_backward_i(surface_backward), .start_x_i(start_x), .start_y_i(start_y),
    .start_z_i(start_z), .azimuth_i(azimuth), .polar_i(polar),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .piece_length_o(piece_length),
    .piece_region_o(piece_region), .piece_track_o(piece_track), .piece_x_o(piece_x),
    .piece_y_o(piece_y), .piece_z_o(piece_z), .piece_surface_forward_o(piece_sfwd),
    .piece_surface_backward_o(piece_sbwd), .slot_index_o(slot_index),
    .last_piece_o(last_piece), .fail_count(fail_count), .pending_pieces(pending_pieces)
  );

  // Receiver: stalls in random bursts, once holds off for a long stretch so that the
  // block keeps its pieces and stalls its input, and goes quiet in the last part of the run.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 600; i++) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_stall <= 1'b1;
        for (int i = 1; i < n; i++) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one segment beat and hold it until the block takes it. The caller has
  // already set the payload; valid stays high across back-to-back beats.
  task automatic send_segment(input bit gap_ok);
    int n;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (gap_ok && !quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 9);
      for (int i = 0; i < n; i++) @(negedge clk);
    end
  endtask

  task automatic load_segment(input bit nt, input logic [23:0] len, input logic [23:0] sig,
                              input logic [15:0] az, input logic [15:0] pol);
    new_track        <= nt;
    seg_length       <= len;
    sigma_max        <= sig;
    region_id        <= 24'($urandom());
    track_index      <= 16'($urandom());
    surface_forward  <= ($urandom_range(0, 4) == 0) ? 21'h1FFFFF : 21'($urandom());
    surface_backward <= ($urandom_range(0, 4) == 0) ? 21'h1FFFFF : 21'($urandom());
    start_x          <= $urandom();
    start_y          <= $urandom();
    start_z          <= $urandom();
    azimuth          <= az;
    polar            <= pol;
  endtask

  // Random segment: mostly cut into a handful of pieces, some whole, some extreme.
  task automatic random_segment();
    logic [23:0] len, sig;
    case ($urandom_range(0, 9))
      0: begin len = 24'($urandom()); sig = 24'($urandom()); end
      1, 2: begin
        len = 24'($urandom_range(0, 24'h0FFFF));
        sig = 24'($urandom_range(0, 24'h1FFFF));
      end
      default: begin
        len = 24'($urandom_range(24'h10000, 24'h3FFFFF));
        sig = 24'($urandom_range(24'h04000, 24'h4FFFF));
      end
    endcase
    load_segment($urandom_range(0, 7) == 0, len, sig, 16'($urandom()), 16'($urandom()));
  endtask

  // Let the block drain before touching the register, waiting until every expected
  // beat has arrived.
  task automatic drain_and_configure(input logic [23:0] value);
    in_valid <= 1'b0;
    while (pending_pieces != 0) @(negedge clk);
    for (int i = 0; i < 200; i++) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [23:0] cfg_vals[5];
    cfg_vals = '{24'd655360, 24'd0, 24'hFFFFFF, 24'd1, 24'd200000};
    for (int i = 0; i < 7; i++) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: default maximum first, then the extremes of each field.
    load_segment(1'b1, 24'd0, 24'd0, 16'd0, 16'd0);            send_segment(1'b1);
    load_segment(1'b0, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'h4000); send_segment(1'b1);
    load_segment(1'b0, 24'h100000, 24'h10000, 16'h4000, 16'h4000); send_segment(1'b1);
    load_segment(1'b0, 24'h100000, 24'h10000, 16'h8000, 16'h2000); send_segment(1'b1);
    // Polar sine zero or negative: emitted whole.
    load_segment(1'b0, 24'hFFFFFF, 24'hFFFFFF, 16'h1234, 16'h8000); send_segment(1'b1);
    load_segment(1'b0, 24'hFFFFFF, 24'hFFFFFF, 16'h1234, 16'hC000); send_segment(1'b1);
    load_segment(1'b1, 24'h0A0000, 24'h10000, 16'hC000, 16'h4000); send_segment(1'b1);
    load_segment(1'b0, 24'h0A0001, 24'h10000, 16'h7FFF, 16'h3FFF); send_segment(1'b1);
    drain_and_configure(24'd0);
    // Zero maximum acts as one: many cuts, saturating at the limit.
    load_segment(1'b0, 24'h000100, 24'h10000, 16'h0, 16'h4000); send_segment(1'b1);
    load_segment(1'b0, 24'hFFFFFF, 24'h000001, 16'h2000, 16'h4000); send_segment(1'b1);
    load_segment(1'b1, 24'h000010, 24'hFFFFFF, 16'hE000, 16'h1000); send_segment(1'b1);
    drain_and_configure(24'hFFFFFF);
    load_segment(1'b0, 24'hFFFFFF, 24'hFFFFFF, 16'h0, 16'h4000); send_segment(1'b1);
    load_segment(1'b0, 24'h123456, 24'h654321, 16'hFFFF, 16'hFFFF); send_segment(1'b1);

    // Random phases under several register settings, the long hold-off in one.
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_configure(ph == 4 ? 24'($urandom_range(1, 24'hFFFFFF)) : cfg_vals[ph]);
      if (ph == 2) hold_request = 1'b1;
      if (ph == 4) quiet_phase = 1'b1;
      for (int i = 0; i < 80; i++) begin
        random_segment();
        send_segment(1'b1);
      end
    end
    in_valid <= 1'b0;
    while (pending_pieces != 0) @(negedge clk);
    for (int i = 0; i < 300; i++) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
